// ----- rtl/psbt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psbt_pkg;

    localparam int LIMIT_W  = 17;
    localparam int NUMBER_W = 16;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = LIMIT_W + 1;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 17'h1FFFF;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_TABLE = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_LIMIT = 3'd0;

    typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

// ----- rtl/psbt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psbt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/prime_sieve_bit_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------
// in        in_valid/in_ready    kind, number
// out       out_valid/out_ready  answer_kind, is_marked, status
// cfg       APB write/read       limit at byte address 0
//
// A query item does one registered read of the bit RAM.
// A build item fills the bit RAM up to limit, clears the multiples of
// each surviving base and scans odd candidates for the next base; the
// single write/read port pair of the bit RAM paces these steps.
// Reset clears control state only; the bit RAM is written by every build.
// A stalled result holds the output register; a new item is taken in the
// cycle the held result leaves.

module prime_sieve_bit_table #(
    parameter int MAX_NUMBERS = 65536
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [psbt_pkg::NUMBER_W-1:0]   number,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 answer_kind,
    output logic                                 is_marked,
    output logic      [psbt_pkg::STATUS_W-1:0]   status,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [psbt_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [psbt_pkg::PDATA_W-1:0]    pwdata,
    output logic      [psbt_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);

    localparam int AW = $clog2(MAX_NUMBERS);
    localparam int CW = psbt_pkg::CNT_W;
    localparam logic [psbt_pkg::LIMIT_W-1:0] LIM_CAP =
        (MAX_NUMBERS > 131071) ? psbt_pkg::LIMIT_MAX : MAX_NUMBERS[psbt_pkg::LIMIT_W-1:0];

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QRD   = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_OUTER = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_SCANW = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                        state_reg, state_next;
    logic [psbt_pkg::LIMIT_W-1:0]      limit_reg, limit_next;
    logic [psbt_pkg::LIMIT_W-1:0]      lim_reg, lim_next;
    logic [psbt_pkg::LIMIT_W-1:0]      built_limit_reg, built_limit_next;
    logic                              table_valid_reg, table_valid_next;
    psbt_pkg::cnt_t                    idx_reg, idx_next;
    psbt_pkg::cnt_t                    base_reg, base_next;
    psbt_pkg::cnt_t                    step_reg, step_next;
    logic [psbt_pkg::STATUS_W-1:0]     q_status_reg, q_status_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              answer_kind_reg, answer_kind_next;
    logic                              is_marked_reg, is_marked_next;
    logic [psbt_pkg::STATUS_W-1:0]     status_reg, status_next;

    logic                              in_fire;
    logic                              out_free;
    logic                              cfg_write;
    logic [2*CW-1:0]                   sq;
    psbt_pkg::cnt_t                    lim_ext;
    logic                              idx_below;
    logic                              ram_we;
    logic                              ram_wdata;
    logic [AW-1:0]                     ram_raddr;
    logic                              ram_rdata;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == psbt_pkg::ADDR_LIMIT)
                       ? psbt_pkg::PDATA_W'(limit_reg) : '0;

    assign sq        = base_reg * base_reg;
    assign lim_ext   = CW'(lim_reg);
    assign idx_below = idx_reg < lim_ext;
    assign ram_we    = ((state_reg == S_FILL) || (state_reg == S_CLEAR)) && idx_below;
    assign ram_wdata = (state_reg == S_FILL);
    assign ram_raddr = (state_reg == S_SCAN) ? AW'(base_reg) : AW'(number);

    psbt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NUMBERS)
    ) u_bits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(idx_reg)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        limit_next       = limit_reg;
        lim_next         = lim_reg;
        built_limit_next = built_limit_reg;
        table_valid_next = table_valid_reg;
        idx_next         = idx_reg;
        base_next        = base_reg;
        step_next        = step_reg;
        q_status_next    = q_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        answer_kind_next = answer_kind_reg;
        is_marked_next   = is_marked_reg;
        status_next      = status_reg;

        if (cfg_write && (paddr == psbt_pkg::ADDR_LIMIT))
        begin
            limit_next = pwdata[psbt_pkg::LIMIT_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == psbt_pkg::KIND_QUERY)
                    begin
                        if (!table_valid_reg)
                        begin
                            q_status_next = psbt_pkg::STATUS_NO_TABLE;
                        end
                        else if ({1'b0, number} >= built_limit_reg)
                        begin
                            q_status_next = psbt_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            q_status_next = psbt_pkg::STATUS_OK;
                        end
                        state_next = S_QRD;
                    end
                    else
                    begin
                        lim_next   = (limit_reg > LIM_CAP) ? LIM_CAP : limit_reg;
                        idx_next   = '0;
                        state_next = S_FILL;
                    end
                end
            end
            S_QRD:
            begin
                out_valid_next   = 1'b1;
                answer_kind_next = psbt_pkg::KIND_QUERY;
                is_marked_next   = (q_status_reg == psbt_pkg::STATUS_OK) && ram_rdata;
                status_next      = q_status_reg;
                state_next       = S_IDLE;
            end
            S_FILL:
            begin
                if (idx_below)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    base_next  = CW'(2);
                    state_next = S_OUTER;
                end
            end
            S_OUTER:
            begin
                if (sq < (2*CW)'(lim_reg))
                begin
                    idx_next   = sq[CW-1:0];
                    step_next  = (base_reg == CW'(2)) ? CW'(2) : {base_reg[CW-2:0], 1'b0};
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                if (idx_below)
                begin
                    idx_next = idx_reg + step_reg;
                end
                else
                begin
                    base_next  = (base_reg == CW'(2)) ? CW'(3) : base_reg + CW'(2);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = (base_reg < lim_ext) ? S_SCANW : S_OUTER;
            end
            S_SCANW:
            begin
                if (ram_rdata)
                begin
                    state_next = S_OUTER;
                end
                else
                begin
                    base_next  = base_reg + CW'(2);
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    answer_kind_next = psbt_pkg::KIND_BUILD;
                    is_marked_next   = 1'b0;
                    status_next      = psbt_pkg::STATUS_OK;
                    built_limit_next = lim_reg;
                    table_valid_next = 1'b1;
                    base_next        = '0;
                    idx_next         = '0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            limit_reg       <= psbt_pkg::LIMIT_RESET;
            lim_reg         <= '0;
            built_limit_reg <= '0;
            table_valid_reg <= 1'b0;
            idx_reg         <= '0;
            base_reg        <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            limit_reg       <= limit_next;
            lim_reg         <= lim_next;
            built_limit_reg <= built_limit_next;
            table_valid_reg <= table_valid_next;
            idx_reg         <= idx_next;
            base_reg        <= base_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_status_reg    <= q_status_next;
        answer_kind_reg <= answer_kind_next;
        is_marked_reg   <= is_marked_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign answer_kind = answer_kind_reg;
    assign is_marked   = is_marked_reg;
    assign status      = status_reg;

    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_QRD || $past(state_reg) == S_DONE))
        else $error("result appeared outside query read or build end");

    a_ok_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && answer_kind_reg == psbt_pkg::KIND_QUERY
         && status_reg == psbt_pkg::STATUS_OK) |-> table_valid_reg)
        else $error("query answered ok without a built table");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (idx_reg < lim_ext && lim_reg <= LIM_CAP))
        else $error("bit RAM write beyond build limit");

    a_build_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && answer_kind_reg == psbt_pkg::KIND_BUILD) |-> table_valid_reg)
        else $error("build result without table valid");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> !(in_fire && $past(state_reg) == S_DONE && !$past(out_free)))
        else $error("item accepted while build result pending");

endmodule

`default_nettype wire
